/* hw/rtl/rsi_pkg.sv */
// Ray-sphere intersection: shared widths and pipeline payload types.
// No dependencies; imported by ray_sphere_intersect.
`default_nettype none

package rsi_pkg;

    // Coordinate format (signed Q16.16) and result formats
    localparam int CW   = 32;          // coordinate width
    localparam int FB   = 16;          // coordinate fraction bits
    localparam int RW   = CW - 1;      // radius width
    localparam int QW   = CW - 1;      // distance width
    localparam int NW   = 16;          // normal width, Q2.14
    localparam int NF   = 14;          // normal fraction bits

    // Input and output word layout
    localparam int IN_W  = 9 * CW + RW;
    localparam int IN_TW = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W = 1 + QW + 3 * CW + 3 * NW;

    // Quadratic terms
    localparam int AW   = 2 * CW;          // A = d.d
    localparam int HDW  = 2 * CW + 1;      // one d*v product
    localparam int HSW  = 2 * CW + 2;      // h = d.v, signed
    localparam int HW   = 2 * CW + 1;      // |h|
    localparam int VW   = 2 * CW + 2;      // v.v and |C|
    localparam int RRW  = 2 * RW;          // r*r
    localparam int SPL  = CW + 1;          // split point of the wide operands
    localparam int PPW  = 2 * SPL;         // partial product width
    localparam int H2W  = 2 * HW;          // h*h and A*|C|
    localparam int DW   = 4 * CW - 2;      // discriminant bits kept
    localparam int SW   = DW / 2;          // floor(sqrt(disc))

    // Root and distance division
    localparam int NUMW = HW + 1;
    localparam int NNW  = NUMW + FB;
    localparam int CMPW = AW + QW;

    // Hit point and normal
    localparam int PRW  = QW + CW;
    localparam int PSW  = PRW - FB + 1;
    localparam int L2W  = 2 * CW + 2;
    localparam int LW   = L2W / 2;
    localparam int MW   = CW;
    localparam int NDW  = MW + NF;
    localparam int NQW  = NF + 1;

    typedef logic [2:0][CW-1:0] t_vec3;

    typedef struct packed {
        t_vec3 o;
        t_vec3 d;
        t_vec3 c;
    } t_geo;

    // Discriminant square root stage
    typedef struct packed {
        logic          miss;
        logic          hneg;
        logic [HW-1:0] hmag;
        logic [AW-1:0] a;
        t_geo          geo;
        logic [DW-1:0] x;
        logic [SW+1:0] rem;
        logic [SW-1:0] root;
    } t_sq1;

    // Distance division stage
    typedef struct packed {
        logic           miss;
        logic           ovf;
        logic [AW-1:0]  a;
        logic [NNW-1:0] n;
        logic [AW-1:0]  rem;
        logic [QW-1:0]  q;
        t_geo           geo;
    } t_dv;

    // Normal length square root stage
    typedef struct packed {
        logic               miss;
        logic [QW-1:0]      tq;
        t_vec3              p;
        logic [2:0]         neg;
        logic [2:0][MW-1:0] mag;
        logic [L2W-1:0]     x;
        logic [LW+1:0]      rem;
        logic [LW-1:0]      root;
    } t_sq2;

    // Normal division stage, three lanes
    typedef struct packed {
        logic                miss;
        logic [QW-1:0]       tq;
        t_vec3               p;
        logic [2:0]          neg;
        logic [2:0][NDW-1:0] n;
        logic [LW-1:0]       len;
        logic [2:0][LW-1:0]  rem;
        logic [2:0][NQW-1:0] q;
    } t_nd;

endpackage

`default_nettype wire

/* hw/rtl/ray_sphere_intersect.sv */
// Ray-sphere intersection top level: fully pipelined quadratic solver.
// Depends on rsi_pkg (widths and stage payload types).
`default_nettype none

// One ray/sphere test per word, one word per clock. Every stage is a register
// slice enabled together, so a new word is taken each cycle whenever the
// output word is empty or being taken. The depth comes from the bit-per-stage
// units: a 63-stage discriminant square root, a 31-stage distance division, a
// 33-stage length square root and a 15-stage normal division, around multiplier
// stages of up to 33x33 bits. A miss gives an all-zero word.
module ray_sphere_intersect (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // ray_origin_x/y/z, ray_dir_x/y/z, center_x/y/z, radius, zero pad
    input  logic [rsi_pkg::IN_TW-1:0] i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // hit, distance, hit_x/y/z, normal_x/y/z
    output logic [rsi_pkg::OUT_W-1:0] o_m_tdata
);
    import rsi_pkg::*;

    logic en;
    logic r_out_vld;
    logic [OUT_W-1:0] r_out;

    // whole pipe advances together; output register parts the two sides
    assign en         = ~r_out_vld | i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out;

    // ---------------- stage 1: v = o - c ----------------
    t_geo in_geo;
    logic r1_vld;
    t_geo r1_geo;
    logic [2:0][CW:0] r1_v;
    logic [RW-1:0] r1_rad;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            in_geo.o[k] = i_s_tdata[k*CW +: CW];
            in_geo.d[k] = i_s_tdata[(3+k)*CW +: CW];
            in_geo.c[k] = i_s_tdata[(6+k)*CW +: CW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_geo <= in_geo;
            r1_rad <= i_s_tdata[9*CW +: RW];
            for (int k = 0; k < 3; k++) begin
                r1_v[k] <= (CW+1)'($signed(in_geo.o[k])) - (CW+1)'($signed(in_geo.c[k]));
            end
        end
    end

    // ---------------- stage 2: component products ----------------
    logic r2_vld;
    t_geo r2_geo;
    logic [2:0][AW-1:0]  r2_dd;
    logic [2:0][HDW-1:0] r2_dv;
    logic [2:0][VW-1:0]  r2_vv;
    logic [RRW-1:0]      r2_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_geo <= r1_geo;
            r2_rr  <= RRW'(r1_rad) * RRW'(r1_rad);
            for (int k = 0; k < 3; k++) begin
                r2_dd[k] <= AW'($signed(r1_geo.d[k])) * AW'($signed(r1_geo.d[k]));
                r2_dv[k] <= HDW'($signed(r1_geo.d[k])) * HDW'($signed(r1_v[k]));
                r2_vv[k] <= VW'($signed(r1_v[k])) * VW'($signed(r1_v[k]));
            end
        end
    end

    // ---------------- stage 3: A, h, v.v ----------------
    logic r3_vld;
    t_geo r3_geo;
    logic [AW-1:0]  r3_a;
    logic [HSW-1:0] r3_h;
    logic [VW-1:0]  r3_vv;
    logic [RRW-1:0] r3_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_geo <= r2_geo;
            r3_rr  <= r2_rr;
            r3_a   <= r2_dd[0] + r2_dd[1] + r2_dd[2];
            r3_h   <= HSW'($signed(r2_dv[0])) + HSW'($signed(r2_dv[1]))
                    + HSW'($signed(r2_dv[2]));
            r3_vv  <= r2_vv[0] + r2_vv[1] + r2_vv[2];
        end
    end

    // ---------------- stage 4: magnitudes of h and C ----------------
    logic r4_vld;
    t_geo r4_geo;
    logic [AW-1:0] r4_a;
    logic          r4_hneg;
    logic [HW-1:0] r4_hmag;
    logic          r4_cneg;
    logic [VW-1:0] r4_cmag;
    logic [HSW-1:0] h_neg;
    logic           c_lt;

    assign h_neg = -r3_h;
    assign c_lt  = r3_vv < VW'(r3_rr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_geo  <= r3_geo;
            r4_a    <= r3_a;
            r4_hneg <= r3_h[HSW-1];
            r4_hmag <= r3_h[HSW-1] ? h_neg[HW-1:0] : r3_h[HW-1:0];
            r4_cneg <= c_lt;
            r4_cmag <= c_lt ? VW'(r3_rr) - r3_vv : r3_vv - VW'(r3_rr);
        end
    end

    // ---------------- stage 5: partial products of h*h and A*|C| ----------------
    logic r5_vld;
    t_geo r5_geo;
    logic [AW-1:0] r5_a;
    logic          r5_hneg;
    logic [HW-1:0] r5_hmag;
    logic          r5_cneg;
    logic [PPW-1:0] r5_hh, r5_hl, r5_ll, r5_ahch, r5_ahcl, r5_alch, r5_alcl;
    logic [HW-SPL-1:0] hh;
    logic [SPL-1:0]    hl, cl;
    logic [VW-SPL-1:0] ch;
    logic [CW-1:0]     ah, al;

    assign hh = r4_hmag[HW-1:SPL];
    assign hl = r4_hmag[SPL-1:0];
    assign ah = r4_a[AW-1:CW];
    assign al = r4_a[CW-1:0];
    assign ch = r4_cmag[VW-1:SPL];
    assign cl = r4_cmag[SPL-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else if (en) begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_geo  <= r4_geo;
            r5_a    <= r4_a;
            r5_hneg <= r4_hneg;
            r5_hmag <= r4_hmag;
            r5_cneg <= r4_cneg;
            r5_hh   <= PPW'(hh) * PPW'(hh);
            r5_hl   <= PPW'(hh) * PPW'(hl);
            r5_ll   <= PPW'(hl) * PPW'(hl);
            r5_ahch <= PPW'(ah) * PPW'(ch);
            r5_ahcl <= PPW'(ah) * PPW'(cl);
            r5_alch <= PPW'(al) * PPW'(ch);
            r5_alcl <= PPW'(al) * PPW'(cl);
        end
    end

    // ---------------- stage 6: assemble h*h and A*|C| ----------------
    logic r6_vld;
    t_geo r6_geo;
    logic [AW-1:0]  r6_a;
    logic           r6_hneg;
    logic [HW-1:0]  r6_hmag;
    logic           r6_cneg;
    logic [H2W-1:0] r6_h2, r6_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_vld <= 1'b0;
        end else if (en) begin
            r6_vld <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_geo  <= r5_geo;
            r6_a    <= r5_a;
            r6_hneg <= r5_hneg;
            r6_hmag <= r5_hmag;
            r6_cneg <= r5_cneg;
            r6_h2   <= (H2W'(r5_hh) << (2*SPL)) + (H2W'(r5_hl) << (SPL+1)) + H2W'(r5_ll);
            r6_ac   <= (H2W'(r5_ahch) << (CW+SPL)) + (H2W'(r5_ahcl) << CW)
                     + (H2W'(r5_alch) << SPL) + H2W'(r5_alcl);
        end
    end

    // ---------------- stage 7: discriminant, then square root ----------------
    t_sq1 r_sq1     [0:SW];
    logic r_sq1_vld [0:SW];
    logic [H2W:0] disc;

    // disc = h*h - A*C, never above A*r*r
    assign disc = r6_cneg ? {1'b0, r6_h2} + {1'b0, r6_ac} : {1'b0, r6_h2} - {1'b0, r6_ac};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq1_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq1_vld[0] <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq1[0].miss <= (r6_a == '0) | disc[H2W];
            r_sq1[0].hneg <= r6_hneg;
            r_sq1[0].hmag <= r6_hmag;
            r_sq1[0].a    <= r6_a;
            r_sq1[0].geo  <= r6_geo;
            r_sq1[0].x    <= disc[DW-1:0];
            r_sq1[0].rem  <= '0;
            r_sq1[0].root <= '0;
        end
    end

    // one root bit per stage, top pair of radicand bits first
    for (genvar j = 0; j < SW; j++) begin : g_sq1
        localparam int I = SW - 1 - j;
        logic [SW+1:0] pre, trial;
        logic          ge;
        t_sq1          n_sq1;

        always_comb begin
            pre   = {r_sq1[j].rem[SW-1:0], r_sq1[j].x[2*I+1 -: 2]};
            trial = {r_sq1[j].root, 2'b01};
            ge    = pre >= trial;
            n_sq1      = r_sq1[j];
            n_sq1.rem  = ge ? pre - trial : pre;
            n_sq1.root = {r_sq1[j].root[SW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq1_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_sq1_vld[j+1] <= r_sq1_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq1[j+1] <= n_sq1;
            end
        end
    end

    // ---------------- root choice: smaller non-negative of -h -/+ s ----------------
    logic r_rt_vld;
    logic r_rt_miss;
    logic [NUMW-1:0] r_rt_num;
    logic [AW-1:0]   r_rt_a;
    t_geo            r_rt_geo;
    logic [HW-1:0]   s_ext;
    logic            h_gt_s;
    logic [NUMW-1:0] num_sel;

    assign s_ext  = HW'(r_sq1[SW].root);
    assign h_gt_s = r_sq1[SW].hmag > s_ext;

    always_comb begin
        if (r_sq1[SW].hneg) begin
            num_sel = h_gt_s || (r_sq1[SW].hmag == s_ext)
                    ? NUMW'(r_sq1[SW].hmag) - NUMW'(s_ext)
                    : NUMW'(r_sq1[SW].hmag) + NUMW'(s_ext);
        end else begin
            num_sel = NUMW'(s_ext) - NUMW'(r_sq1[SW].hmag);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rt_vld <= 1'b0;
        end else if (en) begin
            r_rt_vld <= r_sq1_vld[SW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rt_miss <= r_sq1[SW].miss | (~r_sq1[SW].hneg & h_gt_s);
            r_rt_num  <= num_sel;
            r_rt_a    <= r_sq1[SW].a;
            r_rt_geo  <= r_sq1[SW].geo;
        end
    end

    // ---------------- distance = num * 2^FB / A, saturating ----------------
    t_dv  r_dv     [0:QW];
    logic r_dv_vld [0:QW];
    logic [NNW-1:0] num_sh;

    assign num_sh = {r_rt_num, {FB{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_rt_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0].miss <= r_rt_miss;
            r_dv[0].ovf  <= CMPW'(num_sh) >= {r_rt_a, {QW{1'b0}}};
            r_dv[0].a    <= r_rt_a;
            r_dv[0].n    <= num_sh;
            r_dv[0].rem  <= AW'(num_sh[NNW-1:QW]);
            r_dv[0].q    <= '0;
            r_dv[0].geo  <= r_rt_geo;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < QW; j++) begin : g_dv
        localparam int I = QW - 1 - j;
        logic [AW:0] pre;
        logic        ge;
        t_dv         n_dv;

        always_comb begin
            pre = {r_dv[j].rem, r_dv[j].n[I]};
            ge  = pre >= {1'b0, r_dv[j].a};
            n_dv     = r_dv[j];
            n_dv.rem = ge ? AW'(pre - {1'b0, r_dv[j].a}) : AW'(pre);
            n_dv.q   = {r_dv[j].q[QW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[j+1] <= n_dv;
            end
        end
    end

    // ---------------- hit point: t * d ----------------
    logic r_hm_vld;
    logic r_hm_miss;
    logic [QW-1:0]       r_hm_tq;
    logic [2:0][PRW-1:0] r_hm_prod;
    t_vec3               r_hm_o, r_hm_c;
    logic [QW-1:0]       tq;

    assign tq = r_dv[QW].ovf ? {QW{1'b1}} : r_dv[QW].q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hm_vld <= 1'b0;
        end else if (en) begin
            r_hm_vld <= r_dv_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hm_miss <= r_dv[QW].miss;
            r_hm_tq   <= tq;
            r_hm_o    <= r_dv[QW].geo.o;
            r_hm_c    <= r_dv[QW].geo.c;
            for (int k = 0; k < 3; k++) begin
                r_hm_prod[k] <= PRW'($signed({1'b0, tq})) * PRW'($signed(r_dv[QW].geo.d[k]));
            end
        end
    end

    // ---------------- hit point: o + floor(t*d / 2^FB), saturating ----------------
    logic r_ha_vld;
    logic r_ha_miss;
    logic [QW-1:0] r_ha_tq;
    t_vec3         r_ha_p, r_ha_c;
    logic [2:0][PRW-1:0] prod_sh;
    logic [2:0][PSW-1:0] psum;
    t_vec3               psat;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            prod_sh[k] = $signed(r_hm_prod[k]) >>> FB;
            psum[k]    = PSW'($signed(prod_sh[k][PSW-2:0])) + PSW'($signed(r_hm_o[k]));
            if ((&psum[k][PSW-1:CW-1]) | ~(|psum[k][PSW-1:CW-1])) begin
                psat[k] = psum[k][CW-1:0];
            end else if (psum[k][PSW-1]) begin
                psat[k] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                psat[k] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ha_vld <= 1'b0;
        end else if (en) begin
            r_ha_vld <= r_hm_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ha_miss <= r_hm_miss;
            r_ha_tq   <= r_hm_tq;
            r_ha_p    <= psat;
            r_ha_c    <= r_hm_c;
        end
    end

    // ---------------- m = p - c ----------------
    logic r_mv_vld;
    logic r_mv_miss;
    logic [QW-1:0]     r_mv_tq;
    t_vec3             r_mv_p;
    logic [2:0][CW:0]  r_mv_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv_vld <= 1'b0;
        end else if (en) begin
            r_mv_vld <= r_ha_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mv_miss <= r_ha_miss;
            r_mv_tq   <= r_ha_tq;
            r_mv_p    <= r_ha_p;
            for (int k = 0; k < 3; k++) begin
                r_mv_m[k] <= (CW+1)'($signed(r_ha_p[k])) - (CW+1)'($signed(r_ha_c[k]));
            end
        end
    end

    // ---------------- m squared, sign and magnitude ----------------
    logic r_mm_vld;
    logic r_mm_miss;
    logic [QW-1:0]        r_mm_tq;
    t_vec3                r_mm_p;
    logic [2:0][L2W-1:0]  r_mm_sq;
    logic [2:0]           r_mm_neg;
    logic [2:0][MW-1:0]   r_mm_mag;
    logic [2:0][CW:0]     m_neg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            m_neg[k] = -r_mv_m[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mm_vld <= 1'b0;
        end else if (en) begin
            r_mm_vld <= r_mv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mm_miss <= r_mv_miss;
            r_mm_tq   <= r_mv_tq;
            r_mm_p    <= r_mv_p;
            for (int k = 0; k < 3; k++) begin
                r_mm_sq[k]  <= L2W'($signed(r_mv_m[k])) * L2W'($signed(r_mv_m[k]));
                r_mm_neg[k] <= r_mv_m[k][CW];
                r_mm_mag[k] <= r_mv_m[k][CW] ? m_neg[k][MW-1:0] : r_mv_m[k][MW-1:0];
            end
        end
    end

    // ---------------- |m|^2, then its square root ----------------
    t_sq2 r_sq2     [0:LW];
    logic r_sq2_vld [0:LW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq2_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq2_vld[0] <= r_mm_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq2[0].miss <= r_mm_miss;
            r_sq2[0].tq   <= r_mm_tq;
            r_sq2[0].p    <= r_mm_p;
            r_sq2[0].neg  <= r_mm_neg;
            r_sq2[0].mag  <= r_mm_mag;
            r_sq2[0].x    <= r_mm_sq[0] + r_mm_sq[1] + r_mm_sq[2];
            r_sq2[0].rem  <= '0;
            r_sq2[0].root <= '0;
        end
    end

    for (genvar j = 0; j < LW; j++) begin : g_sq2
        localparam int I = LW - 1 - j;
        logic [LW+1:0] pre, trial;
        logic          ge;
        t_sq2          n_sq2;

        always_comb begin
            pre   = {r_sq2[j].rem[LW-1:0], r_sq2[j].x[2*I+1 -: 2]};
            trial = {r_sq2[j].root, 2'b01};
            ge    = pre >= trial;
            n_sq2      = r_sq2[j];
            n_sq2.rem  = ge ? pre - trial : pre;
            n_sq2.root = {r_sq2[j].root[LW-2:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq2_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_sq2_vld[j+1] <= r_sq2_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq2[j+1] <= n_sq2;
            end
        end
    end

    // ---------------- normal = |m| * 2^14 / len, three lanes ----------------
    // |m_i| never exceeds len, so the quotient stays within one in Q2.14
    t_nd  r_nd     [0:NQW];
    logic r_nd_vld [0:NQW];
    logic [2:0][NDW-1:0] mag_sh;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag_sh[k] = {r_sq2[LW].mag[k], {NF{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nd_vld[0] <= 1'b0;
        end else if (en) begin
            r_nd_vld[0] <= r_sq2_vld[LW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nd[0].miss <= r_sq2[LW].miss;
            r_nd[0].tq   <= r_sq2[LW].tq;
            r_nd[0].p    <= r_sq2[LW].p;
            r_nd[0].neg  <= r_sq2[LW].neg;
            r_nd[0].n    <= mag_sh;
            r_nd[0].len  <= r_sq2[LW].root;
            r_nd[0].q    <= '0;
            for (int k = 0; k < 3; k++) begin
                r_nd[0].rem[k] <= LW'(mag_sh[k][NDW-1:NQW]);
            end
        end
    end

    for (genvar j = 0; j < NQW; j++) begin : g_nd
        localparam int I = NQW - 1 - j;
        logic [2:0][LW:0] pre;
        logic [2:0]       ge;
        t_nd              n_nd;

        always_comb begin
            n_nd = r_nd[j];
            for (int k = 0; k < 3; k++) begin
                pre[k] = {r_nd[j].rem[k], r_nd[j].n[k][I]};
                ge[k]  = pre[k] >= {1'b0, r_nd[j].len};
                n_nd.rem[k] = ge[k] ? LW'(pre[k] - {1'b0, r_nd[j].len}) : LW'(pre[k]);
                n_nd.q[k]   = {r_nd[j].q[k][NQW-2:0], ge[k]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_nd_vld[j+1] <= 1'b0;
            end else if (en) begin
                r_nd_vld[j+1] <= r_nd_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_nd[j+1] <= n_nd;
            end
        end
    end

    // ---------------- output word ----------------
    logic [2:0][NW-1:0] nrm;
    logic [OUT_W-1:0]   n_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_nd[NQW].len == '0) begin
                nrm[k] = '0;
            end else if (r_nd[NQW].neg[k]) begin
                nrm[k] = -NW'(r_nd[NQW].q[k]);
            end else begin
                nrm[k] = NW'(r_nd[NQW].q[k]);
            end
        end
        if (r_nd[NQW].miss) begin
            n_out = '0;
        end else begin
            n_out = {nrm[2], nrm[1], nrm[0], r_nd[NQW].p[2], r_nd[NQW].p[1],
                     r_nd[NQW].p[0], r_nd[NQW].tq, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_nd_vld[NQW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    // ---------------- checks ----------------
    // a miss word carries nothing but zeros
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tdata[0]) |-> (o_m_tdata == '0))
        else $error("miss word with non-zero fields");

    // each normal component lies within one in Q2.14
    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            ($signed(o_m_tdata[1+QW+3*CW +: NW]) <= 16384 &&
             $signed(o_m_tdata[1+QW+3*CW +: NW]) >= -16384 &&
             $signed(o_m_tdata[1+QW+3*CW+NW +: NW]) <= 16384 &&
             $signed(o_m_tdata[1+QW+3*CW+NW +: NW]) >= -16384 &&
             $signed(o_m_tdata[1+QW+3*CW+2*NW +: NW]) <= 16384 &&
             $signed(o_m_tdata[1+QW+3*CW+2*NW +: NW]) >= -16384))
        else $error("normal component out of range");

    // the input side only stalls when a finished word is held up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire

/* bench/tb.sv */
// Testbench for ray_sphere_intersect: directed rows, then random rays, checked
// against a typed result where a row has one, else an exact wide-integer predictor.
// Depends on rsi_pkg and ray_sphere_intersect.
`default_nettype none

module tb;
    import rsi_pkg::*;

    typedef logic signed [255:0] wide_t;

    typedef struct {
        logic signed [31:0] o[3];
        logic signed [31:0] d[3];
        logic signed [31:0] c[3];
        logic [30:0]        rad;
    } ray_t;

    typedef struct {
        logic        hit;
        logic [30:0] distance;
        logic [31:0] p[3];
        logic [15:0] n[3];
    } isect_t;

    localparam int    N_RANDOM   = 1400;
    localparam int    IDLE_LIMIT = 5000;
    localparam int    LONG_STALL = 600;
    localparam wide_t DIST_MAX   = 256'sd2147483647;
    localparam wide_t COORD_MAX  = 256'sd2147483647;
    localparam wide_t COORD_MIN  = -256'sd2147483648;
    localparam wide_t NORM_ONE   = 256'sd16384;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [IN_TW-1:0]   i_s_tdata;
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [OUT_W-1:0]   o_m_tdata;

    ray_sphere_intersect dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Stimulus: rays, whether a row carries a typed result, and that result
    ray_t   rays[$];
    bit     typed[$];
    isect_t typed_res[$];
    isect_t pending_isect[$];

    int     n_sent;
    int     n_taken;
    int     n_out;
    int     n_errors;
    bit     stim_done;
    bit     hold_pause;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Floor square root, operand below 2^182
    function automatic wide_t isqrt(wide_t x);
        wide_t rt;
        wide_t cnd;
        rt = '0;
        for (int i = 90; i >= 0; i--) begin
            cnd = rt | (wide_t'(1) << i);
            if (cnd * cnd <= x) rt = cnd;
        end
        return rt;
    endfunction

    // Exact ray/sphere solution: nearest non-negative root, point, normal
    function automatic isect_t solve_isect(ray_t r);
        wide_t  o[3], d[3], c[3], v[3], p[3], m[3];
        wide_t  a, h, vv, rr, cc, disc, s, num, tq, l2, len, mag, q;
        isect_t res;
        res.hit = 1'b0;
        res.distance = '0;
        for (int i = 0; i < 3; i++) begin
            res.p[i] = '0;
            res.n[i] = '0;
        end
        a = 0; h = 0; vv = 0; l2 = 0;
        for (int i = 0; i < 3; i++) begin
            o[i] = r.o[i];
            d[i] = r.d[i];
            c[i] = r.c[i];
            v[i] = o[i] - c[i];
            a  = a + d[i] * d[i];
            h  = h + d[i] * v[i];
            vv = vv + v[i] * v[i];
        end
        rr   = wide_t'({225'd0, r.rad});
        cc   = vv - rr * rr;
        disc = h * h - a * cc;
        if (a == 0 || disc < 0) return res;
        s   = isqrt(disc);
        num = -h - s;
        if (num < 0) begin
            num = -h + s;
            if (num < 0) return res;
        end
        tq = (num <<< FB) / a;
        if (tq > DIST_MAX) tq = DIST_MAX;
        for (int i = 0; i < 3; i++) begin
            p[i] = o[i] + ((tq * d[i]) >>> FB);
            if (p[i] > COORD_MAX) p[i] = COORD_MAX;
            if (p[i] < COORD_MIN) p[i] = COORD_MIN;
            m[i] = p[i] - c[i];
            l2 = l2 + m[i] * m[i];
        end
        res.hit      = 1'b1;
        res.distance = tq[30:0];
        for (int i = 0; i < 3; i++) res.p[i] = p[i][31:0];
        len = isqrt(l2);
        if (len == 0) return res;
        for (int i = 0; i < 3; i++) begin
            mag = (m[i] < 0) ? -m[i] : m[i];
            q = (mag <<< NF) / len;
            if (q > NORM_ONE) q = NORM_ONE;
            res.n[i] = (m[i] < 0) ? -q[15:0] : q[15:0];
        end
        return res;
    endfunction

    function automatic logic [IN_TW-1:0] pack_ray(ray_t r);
        return {1'b0, r.rad, r.c[2], r.c[1], r.c[0], r.d[2], r.d[1], r.d[0],
                r.o[2], r.o[1], r.o[0]};
    endfunction

    function automatic ray_t mk_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                                    int cx, int cy, int cz, int rad);
        ray_t r;
        r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
        r.d[0] = dx; r.d[1] = dy; r.d[2] = dz;
        r.c[0] = cx; r.c[1] = cy; r.c[2] = cz;
        r.rad  = rad[30:0];
        return r;
    endfunction

    function automatic isect_t mk_isect(logic hit, int distance, int px, int py, int pz,
                                        int nx, int ny, int nz);
        isect_t e;
        e.hit      = hit;
        e.distance = distance[30:0];
        e.p[0] = px; e.p[1] = py; e.p[2] = pz;
        e.n[0] = nx[15:0]; e.n[1] = ny[15:0]; e.n[2] = nz[15:0];
        return e;
    endfunction

    function automatic int rand_s(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    task automatic add_row(ray_t r, bit has_res, isect_t e);
        rays.push_back(r);
        typed.push_back(has_res);
        typed_res.push_back(e);
    endtask

    // Directed table, then random rays
    task automatic build_stimulus();
        localparam int ONE = 65536;
        isect_t miss;
        isect_t none;
        ray_t   r;
        int     cx, cy, cz, ox, oy, oz, rad, sh;
        miss = mk_isect(0, 0, 0, 0, 0, 0, 0, 0);
        none = miss;
        // all zero: zero direction is a miss
        add_row(mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, miss);
        // zero direction, origin inside a sphere: still a miss
        add_row(mk_ray(ONE, 0, 0, 0, 0, 0, 0, 0, 0, 5 * ONE), 1, miss);
        // sphere off the line: negative discriminant
        add_row(mk_ray(0, 0, 0, ONE, 0, 0, 0, 10 * ONE, 0, ONE), 1, miss);
        // sphere behind the origin: both roots negative
        add_row(mk_ray(0, 0, 0, ONE, 0, 0, -10 * ONE, 0, 0, ONE), 1, miss);
        // head-on hit at x = 4, normal pointing back
        add_row(mk_ray(0, 0, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE), 1,
                mk_isect(1, 4 * ONE, 4 * ONE, 0, 0, -16384, 0, 0));
        // origin at a zero-radius centre: t = 0, zero-length normal
        add_row(mk_ray(ONE, 2 * ONE, 3 * ONE, ONE, 0, 0, ONE, 2 * ONE, 3 * ONE, 0), 1,
                mk_isect(1, 0, ONE, 2 * ONE, 3 * ONE, 0, 0, 0));
        // origin inside the sphere: far root taken
        add_row(mk_ray(0, 0, 0, 0, ONE, 0, 0, 0, 0, 3 * ONE), 0, none);
        // tangent grazing
        add_row(mk_ray(0, ONE, 0, ONE, 0, 0, 5 * ONE, 0, 0, ONE), 0, none);
        // tiny direction, far sphere: distance saturates
        add_row(mk_ray(0, 0, 0, 1, 0, 0, 1000 * ONE, 0, 0, ONE), 0, none);
        // hit point beyond the coordinate range
        add_row(mk_ray(32'h7FFF0000, 0, 0, 32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 0, 0,
                       31'h7FFFFFFF), 0, none);
        // field extremes
        add_row(mk_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                       32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                       32'h7FFFFFFF, 31'h7FFFFFFF), 0, none);
        add_row(mk_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                       32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                       32'h80000000, 31'h7FFFFFFF), 0, none);
        add_row(mk_ray(-1, -1, -1, -1, -1, -1, 0, 0, 0, 31'h7FFFFFFF), 0, none);
        add_row(mk_ray(0, 0, 0, 32'h80000000, 0, 0, 32'h80000000, 0, 0, 1), 0, none);
        add_row(mk_ray(3 * ONE, -2 * ONE, ONE, -ONE, ONE, 0, 0, 0, ONE, 2 * ONE), 0, none);

        for (int k = 0; k < N_RANDOM; k++) begin
            sh = $urandom_range(99);
            if (sh < 10) begin
                // unrestricted fields
                r = mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom);
            end else if (sh < 25) begin
                r = mk_ray(rand_s(1 << 22), rand_s(1 << 22), rand_s(1 << 22),
                           rand_s(1 << 18), rand_s(1 << 18), rand_s(1 << 18),
                           rand_s(1 << 22), rand_s(1 << 22), rand_s(1 << 22),
                           $urandom_range(1 << 22));
            end else begin
                // aimed at the sphere, with jitter; sometimes reversed
                cx  = rand_s(1 << 22); cy = rand_s(1 << 22); cz = rand_s(1 << 22);
                rad = $urandom_range(1 << 21, 1 << 15);
                ox  = cx + rand_s(1 << 24); oy = cy + rand_s(1 << 24);
                oz  = cz + rand_s(1 << 24);
                sh  = $urandom_range(8);
                r = mk_ray(ox, oy, oz,
                           ((cx - ox) + rand_s(rad)) >>> sh,
                           ((cy - oy) + rand_s(rad)) >>> sh,
                           ((cz - oz) + rand_s(rad)) >>> sh,
                           cx, cy, cz, rad);
                if ($urandom_range(9) == 0)
                    for (int i = 0; i < 3; i++) r.d[i] = -r.d[i];
            end
            add_row(r, 0, none);
        end
    endtask

    // Sender: bursts and gaps, with one pause until the pipe drains
    initial begin
        int  gap_left;
        int  burst_left;
        bit  xfer;
        bit  paused;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        n_sent     = 0;
        stim_done  = 1'b0;
        hold_pause = 1'b0;
        paused     = 1'b0;
        gap_left   = 0;
        burst_left = 40;
        build_stimulus();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        forever begin
            @(posedge i_clk);
            xfer = i_s_tvalid && o_s_tready;
            if (xfer) n_sent++;
            if (!i_s_tvalid || xfer) begin
                if (n_sent >= rays.size()) begin
                    i_s_tvalid <= 1'b0;
                    stim_done = 1'b1;
                    break;
                end else if (!paused && n_sent == rays.size() / 2) begin
                    hold_pause = 1'b1;
                    i_s_tvalid <= 1'b0;
                    if (pending_isect.size() == 0 && n_taken == n_sent) begin
                        paused = 1'b1;
                        hold_pause = 1'b0;
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                    i_s_tvalid <= 1'b0;
                end else begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= pack_ray(rays[n_sent]);
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(60, 1);
                        gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(12);
                    end
                end
            end
        end
    end

    // Receiver: its own stall pattern, plus one long hold-off
    initial begin
        int  mode;
        int  phase;
        int  stall_left;
        bit  stalled_once;
        i_m_tready   = 1'b0;
        mode         = 0;
        phase        = 0;
        stall_left   = 0;
        stalled_once = 1'b0;
        forever begin
            @(posedge i_clk);
            phase++;
            if (phase % 64 == 0) mode = $urandom_range(3);
            if (!stalled_once && n_out >= 300) begin
                stalled_once = 1'b1;
                stall_left   = LONG_STALL;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                case (mode)
                    0:       i_m_tready <= 1'b1;
                    1:       i_m_tready <= 1'($urandom_range(1));
                    2:       i_m_tready <= ($urandom_range(7) != 0);
                    default: i_m_tready <= ((phase % 5) < 2);
                endcase
            end
        end
    end

    // Record accepted rays and check accepted results
    initial begin
        n_taken  = 0;
        n_out    = 0;
        n_errors = 0;
    end

    always @(posedge i_clk) begin
        isect_t got;
        isect_t want;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            if (typed[n_taken]) pending_isect.push_back(typed_res[n_taken]);
            else pending_isect.push_back(solve_isect(rays[n_taken]));
            n_taken++;
        end
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.hit      = o_m_tdata[0];
            got.distance = o_m_tdata[31:1];
            for (int i = 0; i < 3; i++) begin
                got.p[i] = o_m_tdata[32 + 32 * i +: 32];
                got.n[i] = o_m_tdata[128 + 16 * i +: 16];
            end
            n_out++;
            if (pending_isect.size() == 0) begin
                $error("unexpected result word %h", o_m_tdata);
                n_errors++;
            end else begin
                want = pending_isect.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    n_errors++;
                end
                if (got.distance !== want.distance) begin
                    $error("distance: expected %h, got %h", want.distance, got.distance);
                    n_errors++;
                end
                for (int i = 0; i < 3; i++) begin
                    if (got.p[i] !== want.p[i]) begin
                        $error("hit_%0d: expected %h, got %h", i, want.p[i], got.p[i]);
                        n_errors++;
                    end
                    if (got.n[i] !== want.n[i]) begin
                        $error("normal_%0d: expected %h, got %h", i, want.n[i], got.n[i]);
                        n_errors++;
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no word moving on either side
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) idle = 0;
            else idle++;
            if (idle >= IDLE_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    // End of run: every word taken and answered, then let the pipe run out
    initial begin
        wait (stim_done);
        wait (n_taken == rays.size() && pending_isect.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
